### sv/rppt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppt_pkg
// Shared types, constants and helper functions of the rigid pose transform.
// ----------------------------------------------------------------------------
package rppt_pkg;

	localparam int TRIG_ITERATIONS_DEF = 24;
	localparam int NUM_REGS = 6;
	localparam int XY_W = 34;
	localparam int Z_W = 36;

	typedef logic signed [31:0] coef_t;
	typedef coef_t coef_mat_t [9];

	typedef enum logic [2:0] {
		REG_OFFSET_X = 3'd0,
		REG_OFFSET_Y = 3'd1,
		REG_OFFSET_Z = 3'd2,
		REG_ANGLE_X  = 3'd3,
		REG_ANGLE_Y  = 3'd4,
		REG_ANGLE_Z  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_TRIG,
		ST_MAT,
		ST_DRAIN,
		ST_RUN
	} rebuild_state_t;

	typedef enum logic [1:0] {
		AXIS_X,
		AXIS_Y,
		AXIS_Z
	} axis_t;

	typedef struct packed {
		logic busy;
	} rebuild_status_t;

	localparam logic signed [Z_W-1:0] CORDIC_GAIN = Z_W'(652032874);
	localparam logic signed [Z_W-1:0] PI_Q30 = Z_W'(64'sd3373259426);
	localparam logic signed [Z_W-1:0] HALF_PI_Q30 = Z_W'(1686629713);
	localparam logic signed [31:0] COEF_ONE = 32'sd1073741824;

	function automatic logic signed [Z_W-1:0] atan_q30(input logic [5:0] i);
		logic signed [Z_W-1:0] r;
		r = '0;
		case (i)
			6'd0: r = Z_W'(843314857);
			6'd1: r = Z_W'(497837829);
			6'd2: r = Z_W'(263043837);
			6'd3: r = Z_W'(133525159);
			6'd4: r = Z_W'(67021687);
			6'd5: r = Z_W'(33543516);
			6'd6: r = Z_W'(16775851);
			6'd7: r = Z_W'(8388437);
			6'd8: r = Z_W'(4194283);
			6'd9: r = Z_W'(2097149);
			default: begin
				if (i <= 6'd30) begin
					r = Z_W'(1) <<< (6'd30 - i);
				end else begin
					r = '0;
				end
			end
		endcase
		return r;
	endfunction

	function automatic coef_t clamp_coef(input logic signed [Z_W-1:0] v);
		coef_t r;
		if (v > Z_W'(COEF_ONE)) begin
			r = COEF_ONE;
		end else if (v < -Z_W'(COEF_ONE)) begin
			r = -COEF_ONE;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	function automatic coef_t rot_entry(input axis_t axis, input logic [1:0] row,
			input logic [1:0] col, input coef_t s, input coef_t c);
		coef_t r;
		r = '0;
		case (axis)
			AXIS_X: begin
				if (row == 2'd0 && col == 2'd0) r = COEF_ONE;
				else if (row == 2'd1 && col == 2'd1) r = c;
				else if (row == 2'd1 && col == 2'd2) r = -s;
				else if (row == 2'd2 && col == 2'd1) r = s;
				else if (row == 2'd2 && col == 2'd2) r = c;
			end
			AXIS_Y: begin
				if (row == 2'd0 && col == 2'd0) r = c;
				else if (row == 2'd0 && col == 2'd2) r = s;
				else if (row == 2'd1 && col == 2'd1) r = COEF_ONE;
				else if (row == 2'd2 && col == 2'd0) r = -s;
				else if (row == 2'd2 && col == 2'd2) r = c;
			end
			AXIS_Z: begin
				if (row == 2'd0 && col == 2'd0) r = c;
				else if (row == 2'd0 && col == 2'd1) r = -s;
				else if (row == 2'd1 && col == 2'd0) r = s;
				else if (row == 2'd1 && col == 2'd1) r = c;
				else if (row == 2'd2 && col == 2'd2) r = COEF_ONE;
			end
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### sv/rppt_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppt_cordic
// Iterative CORDIC in rotation mode, one step per cycle while step is high, giving sine and cosine.
// ----------------------------------------------------------------------------
module rppt_cordic
	import rppt_pkg::*;
#(
	parameter int ITER_W = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    load,
	input  logic                    step,
	input  logic [ITER_W-1:0]       iter,
	input  logic signed [15:0]      angle,
	output coef_t                   sin_out,
	output coef_t                   cos_out
);

	logic signed [XY_W-1:0] x_q, y_q, dx, dy, xf, yf;
	logic signed [Z_W-1:0] z_q, z0, at;
	logic flip_q;

	assign z0 = Z_W'(angle) <<< 17;
	assign dx = y_q >>> iter;
	assign dy = x_q >>> iter;
	assign at = atan_q30(6'(iter));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flip_q <= 1'b0;
		end else if (load) begin
			flip_q <= (z0 > HALF_PI_Q30) || (z0 < -HALF_PI_Q30);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			x_q <= XY_W'(CORDIC_GAIN);
			y_q <= '0;
			if (z0 > HALF_PI_Q30) begin
				z_q <= z0 - PI_Q30;
			end else if (z0 < -HALF_PI_Q30) begin
				z_q <= z0 + PI_Q30;
			end else begin
				z_q <= z0;
			end
		end else if (step) begin
			if (z_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign xf = flip_q ? -x_q : x_q;
	assign yf = flip_q ? -y_q : y_q;
	assign cos_out = clamp_coef(Z_W'(xf));
	assign sin_out = clamp_coef(Z_W'(yf));

endmodule

### sv/rppt_rebuild.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppt_rebuild
// Sequencer that builds the rotation matrix Rz*(Rx*Ry) with one shared multiplier.
// ----------------------------------------------------------------------------
module rppt_rebuild
	import rppt_pkg::*;
#(
	parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [15:0] angle_x,
	input  logic signed [15:0] angle_y,
	input  logic signed [15:0] angle_z,
	output coef_mat_t          coef,
	output rebuild_status_t    status
);

	localparam int ITER_W = $clog2(TRIG_ITERATIONS);

	rebuild_state_t state_q, state_d;
	logic [ITER_W-1:0] iter_q;
	logic [1:0] row_q, col_q, k_q;
	logic pass_q;
	logic c_load, c_step, issue, last_issue;
	coef_t sx, cx, sy, cy, sz, cz;
	coef_t a_op, b_op;
	coef_t t_q [9];
	coef_t coef_q [9];
	logic [3:0] b_idx, e_idx;

	logic signed [63:0] prod_s1;
	logic prod_v_s1, prod_first_s1, prod_last_s1, prod_pass_s1;
	logic [3:0] prod_e_s1;
	logic signed [65:0] acc_q, sum;
	logic signed [Z_W-1:0] rounded;

	rppt_cordic #(.ITER_W(ITER_W)) u_cx (.clk(clk), .arst_n(arst_n), .load(c_load),
		.step(c_step), .iter(iter_q), .angle(angle_x), .sin_out(sx), .cos_out(cx));
	rppt_cordic #(.ITER_W(ITER_W)) u_cy (.clk(clk), .arst_n(arst_n), .load(c_load),
		.step(c_step), .iter(iter_q), .angle(angle_y), .sin_out(sy), .cos_out(cy));
	rppt_cordic #(.ITER_W(ITER_W)) u_cz (.clk(clk), .arst_n(arst_n), .load(c_load),
		.step(c_step), .iter(iter_q), .angle(angle_z), .sin_out(sz), .cos_out(cz));

	assign last_issue = (row_q == 2'd2) && (col_q == 2'd2) && (k_q == 2'd2);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD: state_d = ST_TRIG;
			ST_TRIG: if (iter_q == ITER_W'(TRIG_ITERATIONS - 1)) state_d = ST_MAT;
			ST_MAT: if (last_issue && pass_q) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_RUN;
			ST_RUN: state_d = ST_RUN;
			default: state_d = ST_LOAD;
		endcase
		if (start) begin
			state_d = ST_LOAD;
		end
	end

	always_comb begin
		c_load = 1'b0;
		c_step = 1'b0;
		issue = 1'b0;
		status.busy = 1'b1;
		case (state_q)
			ST_LOAD: c_load = 1'b1;
			ST_TRIG: c_step = 1'b1;
			ST_MAT: issue = 1'b1;
			ST_DRAIN: status.busy = 1'b1;
			ST_RUN: status.busy = 1'b0;
			default: status.busy = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			iter_q <= '0;
			row_q <= '0;
			col_q <= '0;
			k_q <= '0;
			pass_q <= 1'b0;
			prod_v_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			prod_v_s1 <= issue;
			if (c_load) begin
				iter_q <= '0;
				row_q <= '0;
				col_q <= '0;
				k_q <= '0;
				pass_q <= 1'b0;
			end else if (c_step) begin
				iter_q <= iter_q + 1'b1;
			end else if (issue) begin
				if (k_q == 2'd2) begin
					k_q <= '0;
					if (col_q == 2'd2) begin
						col_q <= '0;
						if (row_q == 2'd2) begin
							row_q <= '0;
							pass_q <= 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end else begin
						col_q <= col_q + 1'b1;
					end
				end else begin
					k_q <= k_q + 1'b1;
				end
			end
		end
	end

	assign b_idx = {k_q, 1'b0} + 4'(k_q) + 4'(col_q);
	assign e_idx = {row_q, 1'b0} + 4'(row_q) + 4'(col_q);

	always_comb begin
		if (pass_q) begin
			a_op = rot_entry(AXIS_Z, row_q, k_q, sz, cz);
			b_op = t_q[b_idx];
		end else begin
			a_op = rot_entry(AXIS_X, row_q, k_q, sx, cx);
			b_op = rot_entry(AXIS_Y, k_q, col_q, sy, cy);
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= a_op * b_op;
		prod_first_s1 <= (k_q == 2'd0);
		prod_last_s1 <= (k_q == 2'd2);
		prod_pass_s1 <= pass_q;
		prod_e_s1 <= e_idx;
	end

	assign sum = (prod_first_s1 ? 66'sd0 : acc_q) + 66'(prod_s1);
	assign rounded = Z_W'((sum + 66'sd536870912) >>> 30);

	always_ff @(posedge clk) begin
		if (prod_v_s1) begin
			acc_q <= sum;
			if (prod_last_s1) begin
				if (prod_pass_s1) begin
					coef_q[prod_e_s1] <= clamp_coef(rounded);
				end else begin
					t_q[prod_e_s1] <= clamp_coef(rounded);
				end
			end
		end
	end

	assign coef = coef_q;

endmodule

### sv/rppt_point.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rppt_point
// Three-stage point pipeline: input register, products, sum with offset.
// ----------------------------------------------------------------------------
module rppt_point
	import rppt_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_v,
	input  logic signed [31:0] sensor_x,
	input  logic signed [31:0] sensor_y,
	input  logic signed [31:0] sensor_z,
	input  coef_mat_t          coef,
	input  logic signed [31:0] offset_x,
	input  logic signed [31:0] offset_y,
	input  logic signed [31:0] offset_z,
	output logic               out_v,
	output logic signed [31:0] world_x,
	output logic signed [31:0] world_y,
	output logic signed [31:0] world_z
);

	logic v_s1, v_s2, v_s3;
	logic signed [31:0] p_s1 [3];
	logic signed [63:0] prod_s2 [9];
	logic signed [31:0] res_s3 [3];
	logic signed [31:0] res_d [3];
	logic signed [31:0] offs [3];

	assign offs[0] = offset_x;
	assign offs[1] = offset_y;
	assign offs[2] = offset_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		logic signed [65:0] acc;
		logic signed [36:0] v;
		for (int i = 0; i < 3; i++) begin
			acc = 66'(prod_s2[i*3]) + 66'(prod_s2[i*3+1]) + 66'(prod_s2[i*3+2]);
			v = 37'((acc + 66'sd536870912) >>> 30) + 37'(offs[i]);
			if (v > 37'sd2147483647) begin
				res_d[i] = 32'sh7fffffff;
			end else if (v < -37'sd2147483648) begin
				res_d[i] = 32'sh80000000;
			end else begin
				res_d[i] = v[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1[0] <= sensor_z;
			p_s1[1] <= sensor_x;
			p_s1[2] <= sensor_y;
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[i*3+k] <= coef[i*3+k] * p_s1[k];
				end
			end
			res_s3 <= res_d;
		end
	end

	assign out_v = v_s3;
	assign world_x = res_s3[0];
	assign world_y = res_s3[1];
	assign world_z = res_s3[2];

endmodule

### sv/rigid_pose_point_transform_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_pose_point_transform_core
// Maps 3D points from the sensor frame to the world frame.
//
// Points enter on the s_ stream (x, y, z, Q16.16) and leave on the m_ stream
// as world x, y, z, saturated to 32 bits. One beat out for each beat in.
// A new point is taken every cycle while the pipeline advances and no rebuild runs.
// Registers are written on cfg_we with cfg_index and cfg_data. Any write to
// a valid index rebuilds the rotation matrix: three CORDIC units compute
// the sines and cosines, then one shared multiplier forms two 3x3 products.
// s_tready is low during the rebuild.
// After reset the same rebuild runs for the reset pose.
// When m_tready is low the whole pipeline holds only if the output register
// is full; s_tready then drops.
// ----------------------------------------------------------------------------
module rigid_pose_point_transform_core
	import rppt_pkg::*;
#(
	parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [95:0] s_tdata,    // sensor_x, sensor_y, sensor_z
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,    // world_x, world_y, world_z
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	logic signed [31:0] offset_x_q, offset_y_q, offset_z_q;
	logic signed [15:0] angle_x_q, angle_y_q, angle_z_q;
	logic start_q, adv, cfg_hit;
	coef_mat_t coef;
	rebuild_status_t status;
	logic signed [31:0] wx, wy, wz;

	assign cfg_hit = cfg_we && (cfg_index < 3'(NUM_REGS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_x_q <= 32'sd475136;
			offset_y_q <= 32'sd429261;
			offset_z_q <= 32'sd144179;
			angle_x_q <= 16'sd0;
			angle_y_q <= 16'sd6881;
			angle_z_q <= -16'sd12861;
			start_q <= 1'b0;
		end else begin
			start_q <= cfg_hit;
			if (cfg_we) begin
				case (cfg_index)
					REG_OFFSET_X: offset_x_q <= cfg_data;
					REG_OFFSET_Y: offset_y_q <= cfg_data;
					REG_OFFSET_Z: offset_z_q <= cfg_data;
					REG_ANGLE_X: angle_x_q <= cfg_data[15:0];
					REG_ANGLE_Y: angle_y_q <= cfg_data[15:0];
					REG_ANGLE_Z: angle_z_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	rppt_rebuild #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_rebuild (
		.clk(clk), .arst_n(arst_n), .start(start_q),
		.angle_x(angle_x_q), .angle_y(angle_y_q), .angle_z(angle_z_q),
		.coef(coef), .status(status)
	);

	assign adv = !m_tvalid || m_tready;
	assign s_tready = adv && !status.busy && !start_q;

	rppt_point u_point (
		.clk(clk), .arst_n(arst_n), .adv(adv), .in_v(s_tvalid && s_tready),
		.sensor_x(s_tdata[31:0]), .sensor_y(s_tdata[63:32]), .sensor_z(s_tdata[95:64]),
		.coef(coef), .offset_x(offset_x_q), .offset_y(offset_y_q), .offset_z(offset_z_q),
		.out_v(m_tvalid), .world_x(wx), .world_y(wy), .world_z(wz)
	);

	assign m_tdata = {wz, wy, wx};

	a_ready_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !status.busy)
		else $error("input accepted during matrix rebuild");

	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_hit |=> !s_tready)
		else $error("input not blocked after register write");

	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		!status.busy |-> (coef[0] <= COEF_ONE) && (coef[0] >= -COEF_ONE)
			&& (coef[8] <= COEF_ONE) && (coef[8] >= -COEF_ONE))
		else $error("rotation coefficient out of range");

endmodule

### verif/rigid_pose_point_transform_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_pose_point_transform_core_tb
// Self-checking bench for the sensor-to-world point transform.
//
// A local model rebuilds the rotation matrix from the three angle
// registers, using the same CORDIC and fixed-point rounding as the block.
// It predicts the world point for every accepted input beat. Directed tests
// cover the field extremes, saturation, angles beyond pi, excess register
// bits and unused register indexes. Random tests then run under several
// settings and back-pressure patterns.
// ----------------------------------------------------------------------------
module rigid_pose_point_transform_core_tb;
	import rppt_pkg::*;

	localparam int  STALL_LIMIT = 4000;
	localparam int  HOLD_CYCLES = 300;
	localparam int  DRAIN_CYCLES = 8;
	localparam int  TRIG_STEPS = 24;
	localparam longint Q30_ONE = 64'sd1073741824;

	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
	} point_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [95:0] s_tdata;    // sensor_x, sensor_y, sensor_z
	logic        m_tvalid;
	logic        m_tready;
	logic [95:0] m_tdata;    // world_x, world_y, world_z
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	longint pose_reg [NUM_REGS];
	longint rot_mat [9];
	point_t pending_world [$];
	int     error_count;
	int     send_idle_pct;
	int     recv_stall_pct;
	bit     hold_request;
	int     hold_count;
	int     quiet_cycles;

	rigid_pose_point_transform_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	function automatic longint arctan_step(input int i);
		longint head [10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10) return head[i];
		if (i <= 30) return 64'sd1 <<< (30 - i);
		return 0;
	endfunction

	function automatic longint clamp_unit(input longint v);
		return v < -Q30_ONE ? -Q30_ONE : (v > Q30_ONE ? Q30_ONE : v);
	endfunction

	task automatic angle_trig(input longint ang, output longint sn, output longint cs);
		longint z, x, y, dx, dy;
		bit flip;
		z = ang * 131072;
		x = 652032874;
		y = 0;
		flip = 0;
		if (z > 64'sd1686629713) begin
			z -= 64'sd3373259426;
			flip = 1;
		end else if (z < -64'sd1686629713) begin
			z += 64'sd3373259426;
			flip = 1;
		end
		for (int i = 0; i < TRIG_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= arctan_step(i);
			end else begin
				x += dx;
				y -= dy;
				z += arctan_step(i);
			end
		end
		if (flip) begin
			x = -x;
			y = -y;
		end
		cs = clamp_unit(x);
		sn = clamp_unit(y);
	endtask

	task automatic mat_product(input longint a [9], input longint b [9], output longint r [9]);
		longint acc;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				acc = 0;
				for (int k = 0; k < 3; k++) acc += a[i*3+k] * b[k*3+j];
				r[i*3+j] = clamp_unit((acc + (Q30_ONE >>> 1)) >>> 30);
			end
		end
	endtask

	task automatic rebuild_rotation();
		longint sx, cx, sy, cy, sz, cz;
		longint rx [9], ry [9], rz [9], t [9];
		angle_trig(pose_reg[REG_ANGLE_X], sx, cx);
		angle_trig(pose_reg[REG_ANGLE_Y], sy, cy);
		angle_trig(pose_reg[REG_ANGLE_Z], sz, cz);
		rx = '{Q30_ONE, 0, 0, 0, cx, -sx, 0, sx, cx};
		ry = '{cy, 0, sy, 0, Q30_ONE, 0, -sy, 0, cy};
		rz = '{cz, -sz, 0, sz, cz, 0, 0, 0, Q30_ONE};
		mat_product(rx, ry, t);
		mat_product(rz, t, rot_mat);
	endtask

	function automatic point_t to_world(input point_t p);
		longint v [3];
		longint acc, w;
		logic signed [31:0] o [3];
		v = '{longint'(p.z), longint'(p.x), longint'(p.y)};
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int k = 0; k < 3; k++) acc += rot_mat[i*3+k] * v[k];
			w = ((acc + (Q30_ONE >>> 1)) >>> 30) + pose_reg[i];
			if (w > 64'sd2147483647) w = 64'sd2147483647;
			if (w < -64'sd2147483648) w = -64'sd2147483648;
			o[i] = w[31:0];
		end
		return '{o[0], o[1], o[2]};
	endfunction

	// Waits until every expected point has come out and the pipeline is empty.
	task automatic drain_all();
		s_tvalid <= 1'b0;
		while (pending_world.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		drain_all();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx < NUM_REGS) begin
			pose_reg[idx] = idx < REG_ANGLE_X ? longint'($signed(val))
				: longint'($signed(val[15:0]));
			rebuild_rotation();
		end
		@(posedge clk);
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic send_point(input logic signed [31:0] x, input logic signed [31:0] y,
			input logic signed [31:0] z);
		s_tvalid <= 1'b1;
		s_tdata <= {z, y, x};
		do @(posedge clk); while (!s_tready);
		pending_world = {pending_world, to_world('{x, y, z})};
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	function automatic logic signed [31:0] rand_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $urandom_range(1, 0) ? 32'sh7fffffff - $urandom_range(255)
				: 32'sh80000000 + $urandom_range(255);
			default: return $signed($urandom_range(32'h00140000)) - 32'sh000a0000;
		endcase
	endfunction

	function automatic logic [31:0] rand_angle();
		if ($urandom_range(3) == 0) return $urandom;
		return 32'($signed($urandom_range(51472)) - 25736);
	endfunction

	task automatic send_random(input int n);
		repeat (n) send_point(rand_coord(), rand_coord(), rand_coord());
	endtask

	task automatic test_field_extremes();
		logic signed [31:0] ext [6] = '{0, 1, -1, 32'sh7fffffff, 32'sh80000000, 32'sh00010000};
		send_idle_pct = 0;
		recv_stall_pct = 0;
		foreach (ext[i]) send_point(ext[i], ext[i], ext[i]);
		send_point(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
		send_point(32'sh80000000, 32'sh7fffffff, 32'sh80000000);
		send_point(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f);
		send_point(32'shaaaaaaaa, 32'sh55555555, 32'shf0f0f0f0);
	endtask

	task automatic test_register_settings();
		logic [31:0] angles [7] = '{32'd25736, -32'sd25736, 0, 32'h7fff, 32'hffff8000,
			32'd12868, 32'habcd1234};
		write_reg(REG_OFFSET_X, 32'h7fffffff);
		write_reg(REG_OFFSET_Y, 32'h80000000);
		write_reg(REG_OFFSET_Z, 32'h00000000);
		send_point(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
		send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
		foreach (angles[i]) begin
			write_reg(REG_ANGLE_X, angles[i]);
			write_reg(REG_ANGLE_Y, angles[(i + 2) % 7]);
			write_reg(REG_ANGLE_Z, angles[(i + 4) % 7]);
			send_point(32'sh00010000, 32'sh00020000, -32'sh00030000);
		end
		write_reg(3'd6, $urandom);
		write_reg(3'd7, $urandom);
		send_point(32'sh12345678, -32'sh01234567, 32'sh00abcdef);
	endtask

	task automatic test_random_phases();
		int idle_set [4] = '{0, 75, 0, 20};
		int stall_set [4] = '{0, 0, 75, 20};
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = idle_set[ph];
			recv_stall_pct = stall_set[ph];
			for (int blk = 0; blk < 3; blk++) begin
				write_reg(3'($urandom_range(NUM_REGS - 1)), $urandom_range(1) ? rand_angle()
					: $urandom);
				write_reg(REG_ANGLE_X + 3'($urandom_range(2)), rand_angle());
				send_random(95);
			end
		end
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_request = 1'b1;
		send_random(40);
		hold_request = 1'b0;
		send_random(20);
		drain_all();
		send_idle_pct = 20;
		recv_stall_pct = 20;
		send_random(40);
	endtask

	task automatic test_sender_pause();
		write_reg(REG_OFFSET_X, $urandom);
		write_reg(REG_OFFSET_Y, $urandom);
		write_reg(REG_OFFSET_Z, $urandom);
		send_random(30);
		drain_all();
		send_random(30);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_count <= 0;
		end else if (hold_request && hold_count < HOLD_CYCLES) begin
			m_tready <= 1'b0;
			hold_count <= hold_count + 1;
		end else begin
			m_tready <= $urandom_range(99) >= recv_stall_pct;
			if (!hold_request) hold_count <= 0;
		end
	end

	always @(posedge clk) begin
		point_t want;
		if (m_tvalid && m_tready) begin
			if (pending_world.size() == 0) begin
				$error("unexpected world point %h", m_tdata);
				error_count++;
			end else begin
				want = pending_world.pop_front();
				if (m_tdata[31:0] !== want.x) begin
					$error("world_x expected %0d got %0d", want.x, $signed(m_tdata[31:0]));
					error_count++;
				end
				if (m_tdata[63:32] !== want.y) begin
					$error("world_y expected %0d got %0d", want.y, $signed(m_tdata[63:32]));
					error_count++;
				end
				if (m_tdata[95:64] !== want.z) begin
					$error("world_z expected %0d got %0d", want.z, $signed(m_tdata[95:64]));
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		error_count = 0;
		quiet_cycles = 0;
		hold_request = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		pose_reg = '{475136, 429261, 144179, 0, 6881, -12861};
		rebuild_rotation();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_register_settings();
		test_random_phases();
		test_backpressure();
		test_sender_pause();
		drain_all();
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
